@@ rtl/lexq_pkg.sv @@
`timescale 1ns / 1ps
// lexq_pkg: word and command types, status codes for the word lexicon
// no dependencies
package lexq_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_e;

    localparam logic [3:0] ST_INSERTED  = 4'd0;
    localparam logic [3:0] ST_PRESENT   = 4'd1;
    localparam logic [3:0] ST_NO_SLOT   = 4'd2;
    localparam logic [3:0] ST_FULL      = 4'd3;
    localparam logic [3:0] ST_FOUND     = 4'd4;
    localparam logic [3:0] ST_NOT_FOUND = 4'd5;
    localparam logic [3:0] ST_DELETED   = 4'd6;
    localparam logic [3:0] ST_DEL_MISS  = 4'd7;
    localparam logic [3:0] ST_CLEARED   = 4'd8;

    localparam int CFG_W = 9;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] character;
        logic       word_end;
    } in_word_t;

    typedef struct packed {
        logic [3:0] status;
        logic [7:0] slot;
    } out_word_t;

endpackage

@@ rtl/string_lexicon_quadratic_probe_unit.sv @@
`timescale 1ns / 1ps
// word lexicon, open addressing with quadratic probing over a character store
// characters are taken one a cycle while full is low; each queued word is loaded, its sum reduced
// mod m bit by bit, then slots are probed comparing stored characters, and an insert copies bytes
// throughput is one word at a time in the probe engine, a second word may gather meanwhile
// reset: empty table and store, table_slots 16, no clearing pass
// depends on lexq_pkg, lexq_ram, lexq_front, lexq_back
module string_lexicon_quadratic_probe_unit import lexq_pkg::*; #(
    parameter int MAX_SLOTS   = 256,
    parameter int STORE_BYTES = 2048,
    parameter int MAX_WORD    = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  in_word_t         item,
    input  logic             pop,
    output logic             empty,
    output out_word_t        result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);
    localparam int LEN_W = $clog2(MAX_WORD + 1);
    localparam int WB_W  = $clog2(MAX_WORD);
    localparam int SUM_W = $clog2(MAX_WORD * 255 + 1);

    logic [CFG_W-1:0] table_slots_reg;
    logic             wb_wr_en, wb_rd_en;
    logic [WB_W:0]    wb_wr_addr, wb_rd_addr;
    logic [7:0]       wb_wr_data, wb_rd_data;
    logic             job_valid, job_bank, job_done;
    cmd_e             job_cmd;
    logic [LEN_W-1:0] job_len;
    logic [SUM_W-1:0] job_sum;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            table_slots_reg <= CFG_W'(16);
        else if (cfg_valid && cfg_ready)
            table_slots_reg <= cfg_data;
    end

    lexq_front #(.MAX_WORD(MAX_WORD)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .wb_wr_en   (wb_wr_en),
        .wb_wr_addr (wb_wr_addr),
        .wb_wr_data (wb_wr_data),
        .job_valid  (job_valid),
        .job_cmd    (job_cmd),
        .job_len    (job_len),
        .job_sum    (job_sum),
        .job_bank   (job_bank),
        .job_done   (job_done)
    );

    // two banks of word buffer, one per queued word
    lexq_ram #(.WIDTH(8), .DEPTH(2 << WB_W)) u_word_buf (
        .clk     (clk),
        .wr_en   (wb_wr_en),
        .wr_addr (wb_wr_addr),
        .wr_data (wb_wr_data),
        .rd_en   (wb_rd_en),
        .rd_addr (wb_rd_addr),
        .rd_data (wb_rd_data)
    );

    lexq_back #(
        .MAX_SLOTS   (MAX_SLOTS),
        .STORE_BYTES (STORE_BYTES),
        .MAX_WORD    (MAX_WORD)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .table_slots (table_slots_reg),
        .job_valid   (job_valid),
        .job_cmd     (job_cmd),
        .job_len     (job_len),
        .job_sum     (job_sum),
        .job_bank    (job_bank),
        .job_done    (job_done),
        .wb_rd_en    (wb_rd_en),
        .wb_rd_addr  (wb_rd_addr),
        .wb_rd_data  (wb_rd_data),
        .pop         (pop),
        .empty       (empty),
        .result      (result)
    );
endmodule

@@ rtl/lexq_ram.sv @@
`timescale 1ns / 1ps
// lexq_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
module lexq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

@@ rtl/lexq_front.sv @@
`timescale 1ns / 1ps
// lexq_front: gathers characters into a double-banked word buffer, queues word jobs
// depends on lexq_pkg
module lexq_front import lexq_pkg::*; #(
    parameter int MAX_WORD = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  in_word_t                      item,
    output logic                          wb_wr_en,
    output logic [$clog2(MAX_WORD):0]     wb_wr_addr,
    output logic [7:0]                    wb_wr_data,
    output logic                          job_valid,
    output cmd_e                          job_cmd,
    output logic [$clog2(MAX_WORD+1)-1:0] job_len,
    output logic [$clog2(MAX_WORD*255+1)-1:0] job_sum,
    output logic                          job_bank,
    input  logic                          job_done
);
    localparam int LEN_W = $clog2(MAX_WORD + 1);
    localparam int WB_W  = $clog2(MAX_WORD);
    localparam int SUM_W = $clog2(MAX_WORD * 255 + 1);

    logic             bank_reg, bank_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             accept, take_char;

    // two-entry job queue, one entry per word buffer bank
    cmd_e             q_cmd_reg [2];
    logic [LEN_W-1:0] q_len_reg [2];
    logic [SUM_W-1:0] q_sum_reg [2];
    logic             q_bank_reg [2];
    logic             q_wr_reg, q_rd_reg;
    logic [1:0]       q_cnt_reg, q_cnt_next;
    logic             q_push;

    assign full      = (q_cnt_reg == 2'd2);
    assign accept    = push && !full;
    assign take_char = accept && (item.character != 8'd0) && (len_reg < LEN_W'(MAX_WORD));
    assign q_push    = accept && item.word_end;

    assign wb_wr_en   = take_char;
    assign wb_wr_addr = {bank_reg, WB_W'(len_reg)};
    assign wb_wr_data = item.character;

    always_comb
    begin
        len_next  = len_reg;
        sum_next  = sum_reg;
        bank_next = bank_reg;
        if (take_char)
        begin
            len_next = len_reg + LEN_W'(1);
            sum_next = sum_reg + SUM_W'(item.character);
        end
    end

    always_comb
    begin
        q_cnt_next = q_cnt_reg;
        if (q_push && !job_done)
        begin
            q_cnt_next = q_cnt_reg + 2'd1;
        end
        else if (!q_push && job_done)
        begin
            q_cnt_next = q_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg  <= 1'b0;
            len_reg   <= '0;
            sum_reg   <= '0;
            q_wr_reg  <= 1'b0;
            q_rd_reg  <= 1'b0;
            q_cnt_reg <= 2'd0;
        end
        else
        begin
            q_cnt_reg <= q_cnt_next;
            if (job_done)
            begin
                q_rd_reg <= !q_rd_reg;
            end
            if (q_push)
            begin
                bank_reg <= !bank_next;
                len_reg  <= '0;
                sum_reg  <= '0;
                q_wr_reg <= !q_wr_reg;
            end
            else
            begin
                len_reg <= len_next;
                sum_reg <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_cmd_reg[q_wr_reg]  <= cmd_e'(item.command);
            q_len_reg[q_wr_reg]  <= len_next;
            q_sum_reg[q_wr_reg]  <= sum_next;
            q_bank_reg[q_wr_reg] <= bank_reg;
        end
    end

    assign job_valid = (q_cnt_reg != 2'd0);
    assign job_cmd   = q_cmd_reg[q_rd_reg];
    assign job_len   = q_len_reg[q_rd_reg];
    assign job_sum   = q_sum_reg[q_rd_reg];
    assign job_bank  = q_bank_reg[q_rd_reg];
endmodule

@@ rtl/lexq_back.sv @@
`timescale 1ns / 1ps
// lexq_back: probe engine with slot table, character store and result queue
// depends on lexq_pkg, lexq_ram
module lexq_back import lexq_pkg::*; #(
    parameter int MAX_SLOTS   = 256,
    parameter int STORE_BYTES = 2048,
    parameter int MAX_WORD    = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [CFG_W-1:0]              table_slots,
    input  logic                          job_valid,
    input  cmd_e                          job_cmd,
    input  logic [$clog2(MAX_WORD+1)-1:0] job_len,
    input  logic [$clog2(MAX_WORD*255+1)-1:0] job_sum,
    input  logic                          job_bank,
    output logic                          job_done,
    output logic                          wb_rd_en,
    output logic [$clog2(MAX_WORD):0]     wb_rd_addr,
    input  logic [7:0]                    wb_rd_data,
    input  logic                          pop,
    output logic                          empty,
    output out_word_t                     result
);
    localparam int S_W   = $clog2(MAX_SLOTS);
    localparam int M_W   = $clog2(MAX_SLOTS + 1);
    localparam int ST_W  = $clog2(STORE_BYTES);
    localparam int F_W   = $clog2(STORE_BYTES + 1);
    localparam int LEN_W = $clog2(MAX_WORD + 1);
    localparam int WB_W  = $clog2(MAX_WORD);
    localparam int SUM_W = $clog2(MAX_WORD * 255 + 1);
    localparam int BC_W  = $clog2(SUM_W);
    localparam int T_W   = (M_W > CFG_W) ? M_W : CFG_W;
    localparam int CA_W  = ((ST_W > LEN_W) ? ST_W : LEN_W) + 1;
    localparam int FT_W  = ((F_W > LEN_W) ? F_W : LEN_W) + 2;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_MOD    = 10'b0000000010,
        S_PROBE  = 10'b0000000100,
        S_OFF_RD = 10'b0000001000,
        S_CMP_RD = 10'b0000010000,
        S_CMP_CK = 10'b0000100000,
        S_CPY_RD = 10'b0001000000,
        S_CPY_WR = 10'b0010000000,
        S_NEXT   = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } state_e;

    state_e            state_reg, state_next;
    cmd_e              cmd_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic              bank_reg;
    logic [M_W-1:0]    m_reg, rem_reg, sq_reg, odd_reg, i_reg;
    logic [BC_W-1:0]   bit_cnt_reg;
    logic [S_W-1:0]    slot_reg;
    logic [LEN_W-1:0]  k_reg;
    logic [ST_W-1:0]   off_reg;
    logic [F_W-1:0]    fill_reg;
    logic [MAX_SLOTS-1:0] used_reg;
    logic [3:0]        status_reg;
    logic [S_W-1:0]    res_slot_reg;

    logic [T_W-1:0]    ts_ext;
    logic [M_W-1:0]    eff_m;
    logic [M_W:0]      mod_t, probe_t, sq_t, odd_t;
    logic [S_W-1:0]    probe_s;
    logic [CA_W-1:0]   cmp_addr;
    logic [FT_W-1:0]   need;
    logic              fits;
    logic [7:0]        want;
    logic              last_probe;

    // slot offsets and character store
    logic              off_wr_en, off_rd_en, st_wr_en, st_rd_en;
    logic [ST_W-1:0]   off_rd_data, st_wr_addr, st_rd_addr;
    logic [7:0]        st_wr_data, st_rd_data;

    // result queue
    out_word_t         rq_reg [2];
    logic              rq_wr_reg, rq_rd_reg;
    logic [1:0]        rq_cnt_reg;
    logic              rq_push, rq_pop;

    assign ts_ext = T_W'(table_slots);
    always_comb
    begin
        priority if (table_slots == '0)
            eff_m = M_W'(1);
        else if (ts_ext > T_W'(MAX_SLOTS))
            eff_m = M_W'(MAX_SLOTS);
        else
            eff_m = M_W'(ts_ext);
    end

    // one remainder bit per cycle for sum mod m
    always_comb
    begin
        mod_t = {rem_reg, sum_reg[SUM_W-1]};
        if (mod_t >= (M_W+1)'(m_reg))
            mod_t = mod_t - (M_W+1)'(m_reg);
    end

    always_comb
    begin
        probe_t = (M_W+1)'(rem_reg) + (M_W+1)'(sq_reg);
        if (probe_t >= (M_W+1)'(m_reg))
            probe_t = probe_t - (M_W+1)'(m_reg);
        probe_s = S_W'(probe_t);
    end

    // next square: i^2 + (2i+1), odd term steps by two
    always_comb
    begin
        sq_t = (M_W+1)'(sq_reg) + (M_W+1)'(odd_reg);
        if (sq_t >= (M_W+1)'(m_reg))
            sq_t = sq_t - (M_W+1)'(m_reg);
        odd_t = (M_W+1)'(odd_reg) + (M_W+1)'(2);
        if (odd_t >= (M_W+1)'(m_reg))
            odd_t = odd_t - (M_W+1)'(m_reg);
        if (odd_t >= (M_W+1)'(m_reg))
            odd_t = odd_t - (M_W+1)'(m_reg);
    end

    assign last_probe = (i_reg == m_reg - M_W'(1));
    assign cmp_addr   = CA_W'(off_reg) + CA_W'(k_reg);
    assign need       = FT_W'(fill_reg) + FT_W'(len_reg) + FT_W'(1);
    assign fits       = (need <= FT_W'(STORE_BYTES));
    assign want       = (k_reg == len_reg) ? 8'd0 : wb_rd_data;

    assign wb_rd_en   = (state_reg == S_CMP_RD) || (state_reg == S_CPY_RD);
    assign wb_rd_addr = {bank_reg, WB_W'(k_reg)};

    assign off_rd_en  = (state_reg == S_PROBE);
    assign off_wr_en  = (state_reg == S_CPY_WR) && (k_reg == len_reg);
    assign st_rd_en   = (state_reg == S_CMP_RD);
    assign st_rd_addr = ST_W'(cmp_addr);
    assign st_wr_en   = (state_reg == S_CPY_WR);
    assign st_wr_addr = ST_W'(fill_reg) + ST_W'(k_reg);
    assign st_wr_data = want;

    lexq_ram #(.WIDTH(ST_W), .DEPTH(MAX_SLOTS)) u_offsets (
        .clk     (clk),
        .wr_en   (off_wr_en),
        .wr_addr (slot_reg),
        .wr_data (ST_W'(fill_reg)),
        .rd_en   (off_rd_en),
        .rd_addr (probe_s),
        .rd_data (off_rd_data)
    );

    lexq_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    assign rq_push  = (state_reg == S_DONE) && (rq_cnt_reg != 2'd2);
    assign rq_pop   = pop && (rq_cnt_reg != 2'd0);
    assign job_done = rq_push;
    assign empty    = (rq_cnt_reg == 2'd0);
    assign result   = rq_reg[rq_rd_reg];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (job_valid)
                    state_next = (job_cmd == CMD_CLEAR) ? S_DONE : S_MOD;
            S_MOD:
                if (bit_cnt_reg == '0)
                    state_next = S_PROBE;
            S_PROBE:
                if (used_reg[probe_s])
                    state_next = S_OFF_RD;
                else if (cmd_reg == CMD_INSERT)
                    state_next = fits ? S_CPY_RD : S_DONE;
                else
                    state_next = S_NEXT;
            S_OFF_RD:
                state_next = S_CMP_RD;
            S_CMP_RD:
                state_next = (cmp_addr >= CA_W'(STORE_BYTES)) ? S_NEXT : S_CMP_CK;
            S_CMP_CK:
                if (st_rd_data != want)
                    state_next = S_NEXT;
                else if (k_reg == len_reg)
                    state_next = S_DONE;
                else
                    state_next = S_CMP_RD;
            S_CPY_RD:
                state_next = S_CPY_WR;
            S_CPY_WR:
                state_next = (k_reg == len_reg) ? S_DONE : S_CPY_RD;
            S_NEXT:
                state_next = last_probe ? S_DONE : S_PROBE;
            S_DONE:
                if (rq_push)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            used_reg   <= '0;
            rq_wr_reg  <= 1'b0;
            rq_rd_reg  <= 1'b0;
            rq_cnt_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && job_valid && job_cmd == CMD_CLEAR)
            begin
                used_reg <= '0;
                fill_reg <= '0;
            end
            if (state_reg == S_CPY_WR && k_reg == len_reg)
            begin
                used_reg[slot_reg] <= 1'b1;
                fill_reg <= F_W'(need);
            end
            if (state_reg == S_CMP_CK && st_rd_data == want && k_reg == len_reg
                && cmd_reg == CMD_DELETE)
            begin
                used_reg[slot_reg] <= 1'b0;
            end
            if (rq_push)
                rq_wr_reg <= !rq_wr_reg;
            if (rq_pop)
                rq_rd_reg <= !rq_rd_reg;
            if (rq_push && !rq_pop)
                rq_cnt_reg <= rq_cnt_reg + 2'd1;
            else if (!rq_push && rq_pop)
                rq_cnt_reg <= rq_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rq_push)
        begin
            rq_reg[rq_wr_reg].status <= status_reg;
            rq_reg[rq_wr_reg].slot   <= 8'(res_slot_reg);
        end
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_reg      <= job_cmd;
                len_reg      <= job_len;
                sum_reg      <= job_sum;
                bank_reg     <= job_bank;
                m_reg        <= eff_m;
                rem_reg      <= '0;
                bit_cnt_reg  <= BC_W'(SUM_W - 1);
                status_reg   <= ST_CLEARED;
                res_slot_reg <= '0;
            end
            S_MOD:
            begin
                rem_reg     <= M_W'(mod_t);
                sum_reg     <= sum_reg << 1;
                bit_cnt_reg <= bit_cnt_reg - BC_W'(1);
                sq_reg      <= '0;
                odd_reg     <= (m_reg == M_W'(1)) ? M_W'(0) : M_W'(1);
                i_reg       <= '0;
                unique case (cmd_reg)
                    CMD_INSERT: status_reg <= ST_NO_SLOT;
                    CMD_DELETE: status_reg <= ST_DEL_MISS;
                    CMD_SEARCH: status_reg <= ST_NOT_FOUND;
                    CMD_CLEAR:  status_reg <= ST_CLEARED;
                    default:    status_reg <= ST_CLEARED;
                endcase
            end
            S_PROBE:
            begin
                slot_reg <= probe_s;
                k_reg    <= '0;
                if (!used_reg[probe_s] && cmd_reg == CMD_INSERT && !fits)
                    status_reg <= ST_FULL;
            end
            S_OFF_RD:
                off_reg <= off_rd_data;
            S_CMP_RD:
            begin
            end
            S_CMP_CK:
                if (st_rd_data == want)
                begin
                    if (k_reg == len_reg)
                    begin
                        res_slot_reg <= slot_reg;
                        unique case (cmd_reg)
                            CMD_INSERT: status_reg <= ST_PRESENT;
                            CMD_DELETE: status_reg <= ST_DELETED;
                            CMD_SEARCH: status_reg <= ST_FOUND;
                            CMD_CLEAR:  status_reg <= ST_CLEARED;
                            default:    status_reg <= ST_CLEARED;
                        endcase
                    end
                    else
                        k_reg <= k_reg + LEN_W'(1);
                end
            S_CPY_RD:
            begin
            end
            S_CPY_WR:
                if (k_reg == len_reg)
                begin
                    status_reg   <= ST_INSERTED;
                    res_slot_reg <= slot_reg;
                end
                else
                    k_reg <= k_reg + LEN_W'(1);
            S_NEXT:
            begin
                i_reg   <= i_reg + M_W'(1);
                sq_reg  <= M_W'(sq_t);
                odd_reg <= M_W'(odd_t);
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end
endmodule

@@ tb/sv/string_lexicon_quadratic_probe_unit_test.sv @@
`timescale 1ns / 1ps
// testbench for the word lexicon with quadratic probing: directed and random words
// checked against a local predictor; depends on lexq_pkg and string_lexicon_quadratic_probe_unit
module string_lexicon_quadratic_probe_unit_test;
    import lexq_pkg::*;

    localparam int N_SLOTS  = 256;
    localparam int N_BYTES  = 2048;
    localparam int N_CHARS  = 64;
    localparam int IDLE_LIM = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    in_word_t item = '0;
    logic pop = 1'b0;
    logic empty;
    out_word_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;

    string_lexicon_quadratic_probe_unit u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .pop(pop), .empty(empty), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // predictor state
    logic [8:0]  lex_slots_reg;
    logic [10:0] lex_offset [N_SLOTS];
    logic        lex_used [N_SLOTS];
    logic [7:0]  lex_store [N_BYTES];
    int          lex_fill;
    logic [7:0]  lex_word [N_CHARS];
    int          lex_len;
    int          lex_sum;

    out_word_t status_queue [$];
    int  err_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  recv_hold = 1'b0;
    int  idle_cycles = 0;
    int  words_sent = 0;
    int  results_seen = 0;
    int  inserts_seen = 0;
    int  fulls_seen = 0;
    bit  finished = 1'b0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int table_mod();
        if (lex_slots_reg == 0) return 1;
        if (lex_slots_reg > N_SLOTS) return N_SLOTS;
        return lex_slots_reg;
    endfunction

    function automatic bit word_held_at(int s);
        int off;
        logic [7:0] want;
        off = lex_offset[s];
        for (int k = 0; k <= lex_len; k++)
        begin
            want = (k < lex_len) ? lex_word[k] : 8'd0;
            if (off + k >= N_BYTES) return 1'b0;
            if (lex_store[off + k] !== want) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int probe_at(int m, int i);
        return ((lex_sum % m) + ((i * i) % m)) % m;
    endfunction

    function automatic int locate_word(int m);
        int s;
        for (int i = 0; i < m; i++)
        begin
            s = probe_at(m, i);
            if (lex_used[s] && word_held_at(s)) return s;
        end
        return m;
    endfunction

    function automatic void lexicon_reset();
        lex_slots_reg = 9'd16;
        for (int i = 0; i < N_SLOTS; i++)
        begin
            lex_used[i] = 1'b0;
            lex_offset[i] = '0;
        end
        lex_fill = 0;
        lex_len = 0;
        lex_sum = 0;
    endfunction

    // work out the lexicon outcome of one character word
    function automatic void lexicon_step(in_word_t w);
        int m;
        int s;
        out_word_t r;
        m = table_mod();
        r = '0;
        if (w.character != 0 && lex_len < N_CHARS)
        begin
            lex_word[lex_len] = w.character;
            lex_len++;
            lex_sum += w.character;
        end
        if (!w.word_end) return;
        case (cmd_e'(w.command))
            CMD_INSERT:
            begin
                r.status = ST_NO_SLOT;
                for (int i = 0; i < m; i++)
                begin
                    s = probe_at(m, i);
                    if (!lex_used[s])
                    begin
                        if (lex_fill + lex_len + 1 > N_BYTES)
                            r.status = ST_FULL;
                        else
                        begin
                            for (int k = 0; k < lex_len; k++)
                                lex_store[lex_fill + k] = lex_word[k];
                            lex_store[lex_fill + lex_len] = 8'd0;
                            lex_offset[s] = 11'(lex_fill);
                            lex_used[s] = 1'b1;
                            lex_fill += lex_len + 1;
                            r.status = ST_INSERTED;
                            r.slot = 8'(s);
                        end
                        break;
                    end
                    if (word_held_at(s))
                    begin
                        r.status = ST_PRESENT;
                        r.slot = 8'(s);
                        break;
                    end
                end
            end
            CMD_DELETE:
            begin
                s = locate_word(m);
                if (s < m)
                begin
                    lex_used[s] = 1'b0;
                    r.status = ST_DELETED;
                    r.slot = 8'(s);
                end
                else
                    r.status = ST_DEL_MISS;
            end
            CMD_SEARCH:
            begin
                s = locate_word(m);
                if (s < m)
                begin
                    r.status = ST_FOUND;
                    r.slot = 8'(s);
                end
                else
                    r.status = ST_NOT_FOUND;
            end
            default:
            begin
                for (int i = 0; i < N_SLOTS; i++)
                    lex_used[i] = 1'b0;
                lex_fill = 0;
                r.status = ST_CLEARED;
            end
        endcase
        lex_len = 0;
        lex_sum = 0;
        status_queue = {status_queue, r};
    endfunction

    // result checker and watchdog, sampled at the rising edge
    always @(posedge clk)
    begin
        out_word_t exp_r;
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (pop && !empty)
            begin
                results_seen <= results_seen + 1;
                if (status_queue.size() == 0)
                begin
                    $error("unexpected word status=%0d slot=%0d", result.status, result.slot);
                    err_count++;
                end
                else
                begin
                    exp_r = status_queue.pop_front();
                    if (exp_r.status == ST_INSERTED) inserts_seen <= inserts_seen + 1;
                    if (exp_r.status == ST_FULL) fulls_seen <= fulls_seen + 1;
                    if (result.status !== exp_r.status)
                    begin
                        $error("status expected %0d actual %0d", exp_r.status, result.status);
                        err_count++;
                    end
                    if (result.slot !== exp_r.slot)
                    begin
                        $error("slot expected %0d actual %0d", exp_r.slot, result.slot);
                        err_count++;
                    end
                end
            end
            if (idle_cycles >= IDLE_LIM && !finished)
            begin
                $display("timeout, %0d results outstanding", status_queue.size());
                $display("[string_lexicon_quadratic_probe_unit] ERROR");
                $finish;
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        if (recv_hold)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    // push stays high between back to back words and drops only while idling or draining
    task automatic send_char(in_word_t w);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        item <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
        lexicon_step(w);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_word(cmd_e c, string s);
        in_word_t w;
        for (int i = 0; i < s.len(); i++)
        begin
            w.command = c;
            w.character = s[i];
            w.word_end = (i == s.len() - 1);
            send_char(w);
        end
        if (s.len() == 0)
        begin
            w.command = c;
            w.character = 8'd0;
            w.word_end = 1'b1;
            send_char(w);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        while (status_queue.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic write_slots(logic [8:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        lex_slots_reg = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic string rand_text(int maxlen, int alpha);
        string s;
        int n;
        n = $urandom_range(maxlen, 1);
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'(byte'(alpha ? $urandom_range(99, 97) : $urandom_range(255, 1)))};
        return s;
    endfunction

    task automatic test_directed();
        in_word_t w;
        string longw;
        send_word(CMD_SEARCH, "cat");
        send_word(CMD_INSERT, "cat");
        send_word(CMD_INSERT, "act");
        send_word(CMD_INSERT, "cat");
        send_word(CMD_SEARCH, "act");
        send_word(CMD_DELETE, "cat");
        send_word(CMD_DELETE, "cat");
        send_word(CMD_INSERT, "");
        send_word(CMD_SEARCH, "");
        // zero character with the end flag still acts on the gathered word
        w = '{command: CMD_SEARCH, character: 8'h61, word_end: 1'b0};
        send_char(w);
        w = '{command: CMD_SEARCH, character: 8'h00, word_end: 1'b1};
        send_char(w);
        send_word(CMD_INSERT, {8'hff, 8'h01, 8'h80});
        longw = "";
        for (int i = 0; i < 70; i++)
            longw = {longw, "z"};
        send_word(CMD_INSERT, longw);
        send_word(CMD_SEARCH, longw.substr(0, 63));
        send_word(CMD_CLEAR, "q");
        send_word(CMD_SEARCH, "act");
    endtask

    task automatic test_table_sizes();
        write_slots(9'd1);
        send_word(CMD_INSERT, "a");
        send_word(CMD_INSERT, "b");
        send_word(CMD_SEARCH, "a");
        write_slots(9'd0);
        send_word(CMD_SEARCH, "a");
        write_slots(9'd2);
        for (int i = 0; i < 4; i++)
            send_word(CMD_INSERT, rand_text(2, 1));
        write_slots(9'd511);
        send_word(CMD_SEARCH, "a");
        send_word(CMD_INSERT, {8'hff, 8'hff});
        write_slots(9'd256);
        send_word(CMD_INSERT, "b");
        send_word(CMD_CLEAR, "x");
    endtask

    // well-formed word traffic, mostly over a small alphabet so hits are common
    task automatic random_phase(int n, int snd, int rcv);
        int r;
        send_idle_pct = snd;
        recv_stall_pct = rcv;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 45)
                send_word(CMD_INSERT, rand_text(4, 1));
            else if (r < 65)
                send_word(CMD_SEARCH, rand_text(4, 1));
            else if (r < 80)
                send_word(CMD_DELETE, rand_text(4, 1));
            else if (r < 95)
                send_word(cmd_e'($urandom_range(2)), rand_text(6, 0));
            else if (r < 97)
                send_word(CMD_CLEAR, rand_text(2, 0));
            else
                send_word(CMD_INSERT, "");
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_back_pressure();
        fork
        begin
            recv_hold = 1'b1;
            repeat (2000) @(negedge clk);
            recv_hold = 1'b0;
        end
        begin
            for (int i = 0; i < 25; i++)
                send_word(CMD_SEARCH, rand_text(2, 1));
        end
        join
        drain();
    endtask

    initial
    begin
        lexicon_reset();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_table_sizes();
        write_slots(9'd16);
        random_phase(40, 0, 0);
        write_slots(9'd7);
        random_phase(25, 73, 0);
        write_slots(9'd37);
        random_phase(25, 0, 73);
        write_slots(9'd256);
        random_phase(25, 29, 29);
        test_back_pressure();
        write_slots(9'd5);
        random_phase(12, 0, 0);
        drain();
        finished = 1'b1;
        $display("sent %0d characters, checked %0d results (%0d inserts, %0d store full)",
                 words_sent, results_seen, inserts_seen, fulls_seen);
        $display("table sizes 0 to 511, back pressure and all four commands exercised");
        if (err_count == 0 && status_queue.size() == 0)
            $display("[string_lexicon_quadratic_probe_unit] OK");
        else
            $display("[string_lexicon_quadratic_probe_unit] ERROR");
        $finish;
    end
endmodule

@@ files.f @@
rtl/lexq_pkg.sv
rtl/lexq_ram.sv
rtl/lexq_front.sv
rtl/lexq_back.sv
rtl/string_lexicon_quadratic_probe_unit.sv
tb/sv/string_lexicon_quadratic_probe_unit_test.sv
